// File: hw/rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the LED pattern generator: operation and
// pattern codes, configuration register indexes and the sine table.
// ----------------------------------------------------------------------------
package lpg_pkg;

  // Field widths fixed by the interface
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned WRAP_W   = 17;
  localparam int unsigned PAT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes of an input transaction
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CHANGE = 1'b1;

  // Pattern codes; six and seven are stored but behave as not set
  localparam logic [PAT_W-1:0] PAT_NONE     = 3'd0;
  localparam logic [PAT_W-1:0] PAT_BLINK    = 3'd1;
  localparam logic [PAT_W-1:0] PAT_RAMP     = 3'd2;
  localparam logic [PAT_W-1:0] PAT_SINE     = 3'd3;
  localparam logic [PAT_W-1:0] PAT_CONSTANT = 3'd4;
  localparam logic [PAT_W-1:0] PAT_OFF      = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINE_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_WRAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_DUTY = 3'd5;

  // Sine table: one full period, offset to the range 0..254
  localparam int unsigned SINE_ENTRIES = 64;
  localparam int unsigned SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam logic [7:0] SINE_ROM [SINE_ENTRIES] = '{
    8'd127, 8'd139, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd225, 8'd233, 8'd239, 8'd244, 8'd249, 8'd252, 8'd253,
    8'd254, 8'd253, 8'd252, 8'd249, 8'd244, 8'd239, 8'd233, 8'd225,
    8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd139,
    8'd127, 8'd115, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1,
    8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd115
  };

  // Result of one transaction as handed from the core to the output buffer
  typedef struct packed {
    logic              valid;
    logic [DUTY_W-1:0] duty;
  } lpg_result_t;

endpackage

// File: hw/rtl/led_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_pattern_generator
// PWM duty pattern generator for one LED: blink, ramp, sine, constant, off.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle. A tick or a pattern
// change is applied to the pattern state in the cycle it is accepted, and a
// tick that yields a new duty value pushes it into the output buffer, which
// holds two entries, so in_ready stays high while one result waits; it drops
// only when two results are pending, and the throughput of one transaction
// per cycle is then set by out_ready. Configuration writes take effect at
// once and are meant for idle periods.
module led_pattern_generator import lpg_pkg::*; #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [PAT_W-1:0]      in_pattern_sel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     out_duty
);

  lpg_result_t result;
  logic        buf_full;
  logic        accept;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  // Pattern state and per-transaction update
  lpg_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .op          (in_op),
    .pattern_sel (in_pattern_sel),
    .result      (result)
  );

  // Result register and skid stage
  lpg_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_duty  (out_duty)
  );

endmodule

// File: hw/rtl/lpg_core.sv
// ----------------------------------------------------------------------------
// lpg_core
// Configuration registers, pattern state and the per-transaction update.
// State advances at every accepted input; the result is combinational.
// ----------------------------------------------------------------------------
module lpg_core import lpg_pkg::*; #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  input  logic                  op,
  input  logic [PAT_W-1:0]      pattern_sel,
  output lpg_result_t           result
);

  // Duty values are limited to DUTY_BITS and then to the duty field
  localparam logic [DUTY_W-1:0] DUTY_MASK = (DUTY_BITS >= DUTY_W) ? {DUTY_W{1'b1}} :
                                            DUTY_W'((64'd1 << DUTY_BITS) - 64'd1);

  // Configuration registers
  logic [PERIOD_W-1:0] blink_period_r;
  logic [PERIOD_W-1:0] ramp_period_r;
  logic [PERIOD_W-1:0] sine_period_r;
  logic [DUTY_W-1:0]   ramp_limit_r;
  logic [WRAP_W-1:0]   ramp_wrap_r;
  logic [DUTY_W-1:0]   nominal_duty_r;

  // Pattern state
  logic [PERIOD_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [PAT_W-1:0]      cur_pat_r, cur_pat_nxt;
  logic [PAT_W-1:0]      prev_pat_r, prev_pat_nxt;
  logic [SINE_IDX_W-1:0] sine_idx_r, sine_idx_nxt;
  logic [DUTY_W-1:0]     blink_level_r, blink_level_nxt;
  logic [DUTY_W-1:0]     ramp_val_r, ramp_val_nxt;

  logic [PERIOD_W-1:0] cnt_inc;
  logic [WRAP_W-1:0]   ramp_next;
  logic                ramp_wraps;
  logic                res_valid;
  logic [DUTY_W-1:0]   res_duty;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= 32'd500;
      ramp_period_r  <= 32'd10;
      sine_period_r  <= 32'd10;
      ramp_limit_r   <= 16'd255;
      ramp_wrap_r    <= 17'd512;
      nominal_duty_r <= 16'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_PERIOD: blink_period_r <= cfg_wdata;
        REG_RAMP_PERIOD:  ramp_period_r  <= cfg_wdata;
        REG_SINE_PERIOD:  sine_period_r  <= cfg_wdata;
        REG_RAMP_LIMIT:   ramp_limit_r   <= cfg_wdata[DUTY_W-1:0];
        REG_RAMP_WRAP:    ramp_wrap_r    <= cfg_wdata[WRAP_W-1:0];
        REG_NOMINAL_DUTY: nominal_duty_r <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // The advanced ramp value returns to zero at the wrap point, past 16 bits, or when the wrap point is zero
  assign cnt_inc    = tick_cnt_r + 32'd1;
  assign ramp_next  = {1'b0, ramp_val_r} + 17'd1;
  assign ramp_wraps = (ramp_next >= ramp_wrap_r) || ramp_next[WRAP_W-1] ||
                      (ramp_wrap_r == '0);

  // Next state and result of one transaction
  always_comb begin
    tick_cnt_nxt    = tick_cnt_r;
    cur_pat_nxt     = cur_pat_r;
    prev_pat_nxt    = prev_pat_r;
    sine_idx_nxt    = sine_idx_r;
    blink_level_nxt = blink_level_r;
    ramp_val_nxt    = ramp_val_r;
    res_valid       = 1'b0;
    res_duty        = '0;
    if (op == OP_CHANGE) begin
      prev_pat_nxt = cur_pat_r;
      cur_pat_nxt  = pattern_sel;
    end else begin
      tick_cnt_nxt = cnt_inc;
      unique case (cur_pat_r)
        PAT_BLINK: begin
          if (cnt_inc >= blink_period_r) begin
            blink_level_nxt = blink_level_r ^ nominal_duty_r;
            tick_cnt_nxt    = '0;
            res_valid       = 1'b1;
            res_duty        = blink_level_nxt;
          end
        end
        PAT_RAMP: begin
          if (cnt_inc >= ramp_period_r) begin
            res_valid    = 1'b1;
            res_duty     = (ramp_val_r < ramp_limit_r) ? ramp_val_r : '0;
            ramp_val_nxt = ramp_wraps ? '0 : ramp_next[DUTY_W-1:0];
            tick_cnt_nxt = '0;
          end
        end
        PAT_SINE: begin
          if (cnt_inc >= sine_period_r) begin
            res_valid    = 1'b1;
            res_duty     = {8'd0, SINE_ROM[sine_idx_r]};
            sine_idx_nxt = sine_idx_r + 1'b1;
            tick_cnt_nxt = '0;
          end
        end
        PAT_CONSTANT, PAT_OFF: begin
          if (cur_pat_r != prev_pat_r) begin
            res_valid    = 1'b1;
            res_duty     = (cur_pat_r == PAT_CONSTANT) ? nominal_duty_r : '0;
            prev_pat_nxt = cur_pat_r;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers advance only on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r    <= '0;
      cur_pat_r     <= PAT_NONE;
      prev_pat_r    <= PAT_NONE;
      sine_idx_r    <= '0;
      blink_level_r <= '0;
      ramp_val_r    <= '0;
    end else if (accept) begin
      tick_cnt_r    <= tick_cnt_nxt;
      cur_pat_r     <= cur_pat_nxt;
      prev_pat_r    <= prev_pat_nxt;
      sine_idx_r    <= sine_idx_nxt;
      blink_level_r <= blink_level_nxt;
      ramp_val_r    <= ramp_val_nxt;
    end
  end

  assign result.valid = accept && res_valid;
  assign result.duty  = res_duty & DUTY_MASK;

endmodule

// File: hw/rtl/lpg_out_buf.sv
// ----------------------------------------------------------------------------
// lpg_out_buf
// Two-entry output buffer: an output register plus a skid register, so the
// input side keeps moving while one result waits for the consumer.
// ----------------------------------------------------------------------------
module lpg_out_buf import lpg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lpg_result_t       push,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] out_duty
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  logic [DUTY_W-1:0] skid_duty_r, skid_duty_nxt;
  logic              pop;

  assign pop = out_valid_r && out_ready;

  // Queue update; no push arrives while the skid register is occupied
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_duty_nxt   = out_duty_r;
    skid_duty_nxt  = skid_duty_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        out_duty_nxt   = skid_duty_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r) begin
      if (push.valid && pop) begin
        out_duty_nxt = push.duty;
      end else if (push.valid) begin
        skid_duty_nxt  = push.duty;
        skid_valid_nxt = 1'b1;
      end else if (pop) begin
        out_valid_nxt = 1'b0;
      end
    end else begin
      if (push.valid) begin
        out_duty_nxt  = push.duty;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_duty_r  <= out_duty_nxt;
    skid_duty_r <= skid_duty_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;

endmodule

// File: hw/rtl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level assertions for the LED pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker import lpg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] out_duty
);

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty))
    else $error("result changed or vanished while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending after reset");

  // Back-pressure on the input only comes from pending results
  a_ready_low_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A pattern change gives no result
  a_change_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_CHANGE) && !out_valid |=> !out_valid)
    else $error("pattern change transaction produced a result");

  // A full buffer stays full while the consumer stalls
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("buffer drained without a consumer transaction");

endmodule

bind led_pattern_generator lpg_checker u_lpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_duty  (out_duty)
);
